@@ rtl/core/pfe_pkg.sv @@
`timescale 1ns / 1ps
package pfe_pkg;

  localparam int ACC_W   = 16;
  localparam int SPD_W   = 3;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 10;

  localparam logic [SPD_W-1:0] SPEED_RESET = 3'd2;

  typedef enum logic [1:0] {
    ACT_FADE_IN  = 2'd0,
    ACT_FADE_OUT = 2'd1,
    ACT_LOAD     = 2'd2,
    ACT_ELEMENT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_IN   = 2'd1,
    MODE_OUT  = 2'd2
  } mode_t;

  typedef struct packed {
    action_t            action;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic               first_of_frame;
    logic               last_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic [COLOR_W-1:0] out_color;
    logic               done_res;
    logic               fading_in;
  } out_word_t;

endpackage

@@ rtl/core/pfe_ram.sv @@
`timescale 1ns / 1ps
module pfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/palette_fade_engine_top.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake               payload
// in_      input      in_valid / in_ready     in_word  (in_word_t)
// out_     output     out_valid / out_ready   out_word (out_word_t)
// cfg_     input      cfg_we                  cfg_wdata (speed)
//
// one word per cycle while in_ready is high; the accumulator ram is read in stage 0
// and written in stage 1; a write then at once a read of one entry is forwarded
// after reset and each fade-in start a clearing pass over all PALETTE_BYTES entries
// zeroes the ram, in_ready is low for its length; cfg writes are taken as ever
// a stalled result holds in the output register, one more word may sit in stage 1
// reset is synchronous, active low
module palette_fade_engine_top
  import pfe_pkg::*;
#(
  parameter int PALETTE_BYTES = 768,
  parameter int FRACTION_BITS = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [SPD_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(PALETTE_BYTES);
  localparam int SL_W = FRACTION_BITS + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_BYTES - 1);

  logic [SPD_W-1:0] speed_r;
  logic [SPD_W-1:0] eff_speed;
  logic [SL_W-1:0]  arm_steps;

  logic [SL_W-1:0] steps_left_r, steps_left_nxt;
  mode_t           mode_r, mode_nxt;
  logic            done_r, done_nxt;
  logic            frame_r, frame_nxt;
  logic            elem_active;

  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_go;

  logic          in_fire;
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic          s1_take;
  logic          s1_load;

  logic               s1_v_r, s1_v_nxt;
  logic               s1_load_r;
  logic [AW-1:0]      s1_addr_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [ACC_W-1:0]   s1_val_r;
  mode_t              s1_mode_r;
  logic               s1_done_r;
  logic               s1_fire;

  logic [ACC_W-1:0] cur_acc;
  logic [ACC_W-1:0] new_acc;
  logic [ACC_W-1:0] ram_rdata;
  logic [AW-1:0]    ram_raddr;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ACC_W-1:0] ram_wdata;

  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [ACC_W-1:0] fwd_data_r;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  // speed and step count
  assign eff_speed = (32'(speed_r) > FRACTION_BITS) ? SPD_W'(FRACTION_BITS) : speed_r;
  assign arm_steps = SL_W'(1) << (FRACTION_BITS - int'(eff_speed));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
    end else if (cfg_we) begin
      speed_r <= cfg_wdata;
    end
  end

  // stage 0: handshake and scalar state
  assign s1_fire  = s1_v_r && (s1_load_r || !out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_v_r || s1_fire);
  assign in_fire  = in_valid && in_ready;
  assign in_range = 32'(in_word.index) < PALETTE_BYTES;
  assign in_addr  = AW'(in_word.index);

  always_comb begin
    steps_left_nxt = steps_left_r;
    mode_nxt       = mode_r;
    done_nxt       = done_r;
    frame_nxt      = frame_r;
    elem_active    = 1'b0;
    s1_take        = 1'b0;
    s1_load        = 1'b0;
    if (in_fire) begin
      case (in_word.action)
        ACT_FADE_IN, ACT_FADE_OUT: begin
          steps_left_nxt = arm_steps;
          mode_nxt       = (in_word.action == ACT_FADE_IN) ? MODE_IN : MODE_OUT;
          done_nxt       = 1'b0;
          frame_nxt      = 1'b0;
        end
        ACT_LOAD: begin
          s1_load = 1'b1;
          s1_take = in_range;
        end
        default: begin
          if (in_word.first_of_frame) begin
            if (steps_left_r != '0) begin
              steps_left_nxt = steps_left_r - SL_W'(1);
              frame_nxt      = 1'b1;
            end else begin
              frame_nxt = 1'b0;
            end
          end
          elem_active = frame_nxt;
          if (in_word.last_of_frame) begin
            if (elem_active && steps_left_nxt == '0) begin
              done_nxt = 1'b1;
            end
            frame_nxt = 1'b0;
          end
          s1_take = elem_active && in_range;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r <= '0;
      mode_r       <= MODE_NONE;
      done_r       <= 1'b0;
      frame_r      <= 1'b0;
    end else begin
      steps_left_r <= steps_left_nxt;
      mode_r       <= mode_nxt;
      done_r       <= done_nxt;
      frame_r      <= frame_nxt;
    end
  end

  // clearing pass
  assign clr_go = clr_busy_r && !s1_v_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_go) begin
      if (clr_cnt_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
    end
    if (in_fire && in_word.action == ACT_FADE_IN) begin
      clr_busy_nxt = 1'b1;
      clr_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // stage 1 register
  assign s1_v_nxt = (s1_v_r && !s1_fire) ? 1'b1 : s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s1_take) begin
      s1_load_r <= s1_load;
      s1_addr_r <= in_addr;
      s1_idx_r  <= in_word.index;
      s1_val_r  <= s1_load ? (ACC_W'(in_word.color) << FRACTION_BITS)
                           : (ACC_W'(in_word.color) << eff_speed);
      s1_mode_r <= mode_r;
      s1_done_r <= done_nxt;
    end
  end

  // accumulator ram
  assign ram_raddr = (s1_v_r && !s1_fire) ? s1_addr_r : in_addr;

  pfe_ram #(
    .WIDTH (ACC_W),
    .DEPTH (PALETTE_BYTES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stage 1: modify and write back
  assign cur_acc = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;

  always_comb begin
    new_acc = cur_acc;
    if (s1_load_r) begin
      new_acc = s1_val_r;
    end else begin
      case (s1_mode_r)
        MODE_IN:  new_acc = cur_acc + s1_val_r;
        MODE_OUT: new_acc = (cur_acc > s1_val_r) ? cur_acc - s1_val_r : '0;
        default:  new_acc = cur_acc;
      endcase
    end
  end

  assign ram_we    = clr_go || s1_fire;
  assign ram_waddr = clr_go ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = clr_go ? '0 : new_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (clr_busy_r) begin
      fwd_v_r <= 1'b0;
    end else if (s1_fire) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_acc;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && !s1_load_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !s1_load_r) begin
      out_word_r.out_index <= s1_idx_r;
      out_word_r.out_color <= COLOR_W'(new_acc >> FRACTION_BITS);
      out_word_r.done_res  <= s1_done_r;
      out_word_r.fading_in <= (s1_mode_r == MODE_IN);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  a_clr_no_s1_write: assert property (@(posedge clk) disable iff (!rst_n)
    clr_go |-> !s1_fire)
    else $error("clearing pass overlaps a stage 1 write");

  a_fade_in_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.action == ACT_FADE_IN) |=> (clr_busy_r && clr_cnt_r == '0))
    else $error("fade-in start did not launch a clearing pass");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_left_r) <= (1 << FRACTION_BITS))
    else $error("step count above its armed maximum");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_fire) |=> (s1_v_r && $stable(s1_addr_r) && $stable(s1_val_r)))
    else $error("stalled stage 1 word changed");

endmodule
